[rtl/mfd_pkg.sv]
// ----------------------------------------------------------------------------
// mfd_pkg - shared definitions for the motor feedback decoder
// Field widths, encoder and turn counter sizes, register map.
// ----------------------------------------------------------------------------
package mfd_pkg;

  // encoder resolution and turn counter size
  localparam int ENC_BITS  = 13;
  localparam int TURN_BITS = 24;
  localparam int HALF_TURN = 1 << (ENC_BITS - 1);

  // angle scaling: degrees with 16 fraction bits
  localparam int DEG_PER_TURN = 360;
  localparam int FRAC_BITS    = 16;
  localparam int ANG_SHIFT    = FRAC_BITS - ENC_BITS;

  // payload widths
  localparam int SPEED_W  = 16;
  localparam int CURR_W   = 16;
  localparam int TEMP_W   = 8;
  localparam int SINGLE_W = 25;
  localparam int TOTAL_W  = 49;
  localparam int COEF_W   = 16;
  localparam int ACC_W    = 32;

  localparam logic [SINGLE_W-1:0] ANGLE_SINGLE_MAX = SINGLE_W'(23590080);

  // APB register map
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic {
    REG_SPEED_COEF   = 1'b0,
    REG_CURRENT_COEF = 1'b1
  } mfd_reg_t;

endpackage

[rtl/mfd_if.sv]
// ----------------------------------------------------------------------------
// mfd_if - transfer channels of the motor feedback decoder
// Valid/ready channels for feedback frames and decoded results.
// ----------------------------------------------------------------------------
interface mfd_in_if;
  import mfd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [ENC_BITS-1:0] encoder_count;
  logic signed [SPEED_W-1:0]  speed_raw;
  logic signed [CURR_W-1:0]   current_raw;
  logic        [TEMP_W-1:0]   temp_raw;

  modport source (output valid, encoder_count, speed_raw, current_raw, temp_raw,
                  input ready);
  modport sink   (input valid, encoder_count, speed_raw, current_raw, temp_raw,
                  output ready);
endinterface

interface mfd_out_if;
  import mfd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [SINGLE_W-1:0] angle_single;
  logic signed [TOTAL_W-1:0]  angle_total;
  logic signed [SPEED_W-1:0]  speed_smoothed;
  logic signed [CURR_W-1:0]   current_smoothed;
  logic        [TEMP_W-1:0]   temperature;

  modport source (output valid, angle_single, angle_total, speed_smoothed,
                  current_smoothed, temperature, input ready);
  modport sink   (input valid, angle_single, angle_total, speed_smoothed,
                  current_smoothed, temperature, output ready);
endinterface

[rtl/motor_feedback_decoder.sv]
// ----------------------------------------------------------------------------
// motor_feedback_decoder - multi-turn encoder unwrap with speed/current smoothing
//
// Channels:
//   in_ch  : one feedback frame per transfer (encoder count, speed, current,
//            temperature), valid/ready.
//   out_ch : one result per frame (single-turn angle, multi-turn angle,
//            smoothed speed and current, temperature), valid/ready.
//   APB    : two 16-bit smoothing weights at 0x0 (speed) and 0x4 (current),
//            Q0.16 weight of the old value. Write only while idle.
// Pipeline: input register, then result register; the result is valid once
//   its frame has moved through both. Throughput: one frame per cycle while
//   out_ch.ready holds high; the turn tracker and both smoothing filters update
//   in the same cycle an item moves into the result register, so the next
//   frame sees the new state right away.
// Reset (rst_n low, synchronous): both pipeline registers empty, previous count,
//   turn counter, accumulators and weights cleared to zero.
// Stall: while out_ch.ready is low the result holds; one more frame is taken
//   into the input register, then in_ch.ready drops until the result moves.
// ----------------------------------------------------------------------------
module motor_feedback_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  mfd_in_if.sink                        in_ch,
  mfd_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfd_pkg::APB_AW-1:0]    paddr,
  input  logic [mfd_pkg::APB_DW-1:0]    pwdata,
  output logic [mfd_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import mfd_pkg::*;

  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [COEF_W-1:0] speed_coef_r;
  logic [COEF_W-1:0] curr_coef_r;
  logic              cfg_wr;
  mfd_reg_t          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = mfd_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_coef_r <= '0;
      curr_coef_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_SPEED_COEF:   speed_coef_r <= pwdata[COEF_W-1:0];
        REG_CURRENT_COEF: curr_coef_r  <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_SPEED_COEF:   prdata = APB_DW'(speed_coef_r);
      REG_CURRENT_COEF: prdata = APB_DW'(curr_coef_r);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic in_valid_r;
  logic out_valid_r;
  logic advance;
  logic in_take;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_valid_r <= in_ch.valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // input register (payload, no reset)
  logic        [ENC_BITS-1:0] count_r;
  logic signed [SPEED_W-1:0]  speed_r;
  logic signed [CURR_W-1:0]   curr_r;
  logic        [TEMP_W-1:0]   temp_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      count_r <= in_ch.encoder_count;
      speed_r <= in_ch.speed_raw;
      curr_r  <= in_ch.current_raw;
      temp_r  <= in_ch.temp_raw;
    end
  end

  // --------------------------------------------------------------------------
  // turn tracking
  // --------------------------------------------------------------------------
  logic        [ENC_BITS-1:0]  prev_enc_r;
  logic signed [TURN_BITS-1:0] turn_r;
  logic signed [TURN_BITS-1:0] turn_nxt;
  logic        [ENC_BITS:0]    count_half;
  logic        [ENC_BITS:0]    prev_half;
  logic                        wrap_up;
  logic                        wrap_down;

  // jump below minus half a turn: wrapped forward; above plus half: backward
  assign count_half = {1'b0, count_r} + (ENC_BITS+1)'(HALF_TURN);
  assign prev_half  = {1'b0, prev_enc_r} + (ENC_BITS+1)'(HALF_TURN);
  assign wrap_up    = {1'b0, prev_enc_r} > count_half;
  assign wrap_down  = {1'b0, count_r} > prev_half;

  always_comb begin
    turn_nxt = turn_r;
    if (wrap_up && (turn_r != TURN_MAX))
      turn_nxt = turn_r + TURN_BITS'(1);
    else if (wrap_down && (turn_r != TURN_MIN))
      turn_nxt = turn_r - TURN_BITS'(1);
  end

  // angles: count * 360 scaled to 16 fraction bits; total adds whole turns
  logic        [SINGLE_W-1:0] single;
  logic signed [63:0]         total_w;

  assign single  = (SINGLE_W'(count_r) * SINGLE_W'(DEG_PER_TURN)) << ANG_SHIFT;
  assign total_w = ((64'(turn_nxt) * 64'sd360) <<< FRAC_BITS) + 64'(single);

  // --------------------------------------------------------------------------
  // first-order smoothing: acc' = (1 - c) * x + floor(c * acc), Q16.16
  // --------------------------------------------------------------------------
  function automatic logic signed [ACC_W-1:0] smooth(
    input logic signed [ACC_W-1:0]   acc,
    input logic signed [SPEED_W-1:0] x,
    input logic        [COEF_W-1:0]  c
  );
    logic        [COEF_W:0]          keep;
    logic signed [COEF_W+ACC_W:0]    old_part;
    logic signed [COEF_W+SPEED_W+1:0] fresh;
    logic signed [COEF_W+SPEED_W+1:0] sum;
    keep     = (COEF_W+1)'(1 << COEF_W) - {1'b0, c};
    old_part = $signed({1'b0, c}) * acc;
    fresh    = $signed({1'b0, keep}) * x;
    sum      = fresh + (COEF_W+SPEED_W+2)'(old_part[COEF_W+ACC_W-1:FRAC_BITS]);
    return sum[ACC_W-1:0];
  endfunction

  logic signed [ACC_W-1:0] speed_acc_r;
  logic signed [ACC_W-1:0] curr_acc_r;
  logic signed [ACC_W-1:0] speed_acc_nxt;
  logic signed [ACC_W-1:0] curr_acc_nxt;

  assign speed_acc_nxt = smooth(speed_acc_r, speed_r, speed_coef_r);
  assign curr_acc_nxt  = smooth(curr_acc_r, curr_r, curr_coef_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_enc_r  <= '0;
      turn_r      <= '0;
      speed_acc_r <= '0;
      curr_acc_r  <= '0;
    end else if (advance) begin
      prev_enc_r  <= count_r;
      turn_r      <= turn_nxt;
      speed_acc_r <= speed_acc_nxt;
      curr_acc_r  <= curr_acc_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic        [SINGLE_W-1:0] single_r;
  logic signed [TOTAL_W-1:0]  total_r;
  logic signed [SPEED_W-1:0]  speed_out_r;
  logic signed [CURR_W-1:0]   curr_out_r;
  logic        [TEMP_W-1:0]   temp_out_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      single_r    <= single;
      total_r     <= total_w[TOTAL_W-1:0];
      speed_out_r <= speed_acc_nxt[ACC_W-1:FRAC_BITS];
      curr_out_r  <= curr_acc_nxt[ACC_W-1:FRAC_BITS];
      temp_out_r  <= temp_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.angle_single     = single_r;
  assign out_ch.angle_total      = total_r;
  assign out_ch.speed_smoothed   = speed_out_r;
  assign out_ch.current_smoothed = curr_out_r;
  assign out_ch.temperature      = temp_out_r;

endmodule

[rtl/mfd_checker.sv]
// ----------------------------------------------------------------------------
// mfd_checker - port-level checks for the motor feedback decoder
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
module mfd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mfd_pkg::SINGLE_W-1:0]  angle_single,
  input logic [mfd_pkg::TOTAL_W-1:0]   angle_total
);
  import mfd_pkg::*;

  // no result directly out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(angle_total) && $stable(angle_single))
    else $error("stalled result changed");

  // whole turns add no fraction bits: total and single share the fraction
  a_frac_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> angle_total[FRAC_BITS-1:0] == angle_single[FRAC_BITS-1:0])
    else $error("multi-turn fraction differs from single-turn fraction");

  // single-turn angle stays below one turn
  a_single_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> angle_single <= ANGLE_SINGLE_MAX)
    else $error("single-turn angle out of range");

endmodule

bind motor_feedback_decoder mfd_checker u_mfd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .angle_single (out_ch.angle_single),
  .angle_total  (out_ch.angle_total)
);

[test/tb_motor_feedback_decoder.sv]
// ----------------------------------------------------------------------------
// tb_motor_feedback_decoder - self-checking bench for the feedback decoder
// Drives feedback frames over the input channel and checks every result in
// order against a cycle-free model of the turn tracker and both smoothing
// filters. A directed table covers wrap and half-turn cases, then random
// phases run under several smoothing weights with random idling, one
// idle-free phase and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_motor_feedback_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import mfd_pkg::*;

  localparam int ITEMS_PER_PHASE = 300;
  localparam int N_PHASES        = 6;
  localparam int N_DIRECTED      = 16;
  localparam int HOLD_CYCLES     = 80;   // receiver hold-off, long enough to fill the pipe
  localparam int WATCHDOG_LIMIT  = 2000; // cycles without any transfer
  localparam int REPORT_MAX      = 10;
  localparam int IDLE_PCT        = 6;

  localparam longint TURN_HI = (longint'(1) <<< (TURN_BITS - 1)) - 1;
  localparam longint TURN_LO = -TURN_HI - 1;

  typedef struct packed {
    logic        [ENC_BITS-1:0] enc;
    logic signed [SPEED_W-1:0]  spd;
    logic signed [CURR_W-1:0]   cur;
    logic        [TEMP_W-1:0]   tmp;
  } frame_t;

  typedef struct packed {
    logic        [SINGLE_W-1:0] single;
    logic signed [TOTAL_W-1:0]  total;
    logic signed [SPEED_W-1:0]  speed;
    logic signed [CURR_W-1:0]   current;
    logic        [TEMP_W-1:0]   temp;
  } angle_result_t;

  // directed row: frame, plus a hand-worked result where one is given
  typedef struct packed {
    frame_t        frm;
    logic          fixed;
    angle_result_t res;
  } stim_row_t;

  // ------------------------------------------------------------------------
  // clock, reset, DUT
  // ------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mfd_in_if  in_if ();
  mfd_out_if out_if ();

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  motor_feedback_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ------------------------------------------------------------------------
  // decoder model state and the queue of results still owed by the DUT
  // ------------------------------------------------------------------------
  logic [ENC_BITS-1:0] last_count;
  longint              turns;
  longint              speed_acc;
  longint              curr_acc;
  logic [COEF_W-1:0]   speed_coef;
  logic [COEF_W-1:0]   curr_coef;

  angle_result_t pending_results[$];
  int            mismatches;

  // stimulus controls shared with the receiver process
  bit idle_en  = 1'b1;
  bit hold_req = 1'b0;

  // random rotor walk
  int enc_pos = 0;
  int spin    = 1;

  // Directed frames, all at reset weights (zero), so smoothed values equal
  // the raw ones. The first frame lands above half a turn right after reset,
  // so it counts a turn down against the cleared previous count.
  stim_row_t dir_table [N_DIRECTED] = '{
    '{'{8191,  32767, -32768, 255}, 1'b1, '{23590080,     -2880,  32767, -32768, 255}},
    '{'{   0, -32768,  32767,   0}, 1'b1, '{       0,         0, -32768,  32767,   0}},
    // jumps of exactly half a turn count nothing
    '{'{4096,      0,      0,   1}, 1'b1, '{11796480,  11796480,      0,      0,   1}},
    '{'{   0,      1,     -1, 128}, 1'b1, '{       0,         0,      1,     -1, 128}},
    // one count past half a turn does
    '{'{4097,     -1,      1, 127}, 1'b1, '{11799360, -11793600,     -1,      1, 127}},
    '{'{   0,    100,   -100,  25}, 1'b1, '{       0,         0,    100,   -100,  25}},
    '{'{4095,  21845, -21846, 170}, 1'b0, '0},
    '{'{8191, -21846,  21845,  85}, 1'b0, '0},
    '{'{   0,    255,   -256,  15}, 1'b0, '0},
    '{'{5461,  -4096,   4095, 240}, 1'b0, '0},
    '{'{2730,   4096,  -4097,  60}, 1'b0, '0},
    '{'{8000,     -2,      2, 200}, 1'b0, '0},
    '{'{ 100,      7,     -7,  99}, 1'b0, '0},
    '{'{8100,  12345, -12345,  42}, 1'b0, '0},
    '{'{ 200, -12345,  12345, 201}, 1'b0, '0},
    '{'{ 300,      0,     -1,  77}, 1'b0, '0}
  };

  // Q16.16 first-order filter, floor rounding: c/65536 weight on the old value
  function automatic longint smooth_acc(longint acc, longint x, logic [COEF_W-1:0] c);
    longint cw;
    longint sum;
    cw  = longint'(c);
    sum = (65536 - cw) * (x * 65536) + cw * acc;
    return sum >>> FRAC_BITS;
  endfunction

  // advance the decoder model by one frame and return its result
  function automatic angle_result_t decode_frame(frame_t f);
    angle_result_t r;
    longint        diff;
    longint        single;
    longint        total;
    diff = longint'(f.enc) - longint'(last_count);
    // wrap forward through zero -> turn up, backward through zero -> turn down;
    // counter saturates instead of wrapping
    if (diff < -HALF_TURN) begin
      if (turns < TURN_HI) turns++;
    end else if (diff > HALF_TURN) begin
      if (turns > TURN_LO) turns--;
    end
    last_count = f.enc;

    single = (longint'(f.enc) * DEG_PER_TURN) <<< ANG_SHIFT;
    total  = turns * DEG_PER_TURN * 65536 + single;

    speed_acc = smooth_acc(speed_acc, f.spd, speed_coef);
    curr_acc  = smooth_acc(curr_acc, f.cur, curr_coef);

    r.single  = SINGLE_W'(single);
    r.total   = TOTAL_W'(total);
    r.speed   = SPEED_W'(speed_acc >>> FRAC_BITS);
    r.current = CURR_W'(curr_acc >>> FRAC_BITS);
    r.temp    = f.tmp;
    return r;
  endfunction

  // random frame: mostly a rotor that keeps turning one way for a while,
  // plus near-half-turn jumps, extremes and plain random counts
  function automatic frame_t next_frame();
    frame_t f;
    int     pick;
    int     step;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 2) spin = -spin;
    if (pick < 55) begin
      step = spin * int'($urandom_range(0, 600));
      if ($urandom_range(0, 9) == 0) step = -step;
    end else if (pick < 70) begin
      step = 4095 + int'($urandom_range(0, 2));
      if ($urandom_range(0, 1) == 1) step = -step;
    end else begin
      step = 0;
    end
    if (pick >= 70 && pick < 80)
      enc_pos = ($urandom_range(0, 1) == 1) ? 8191 : 0;
    else if (pick >= 80)
      enc_pos = int'($urandom_range(0, 8191));
    else
      enc_pos = (enc_pos + step) & 8191;
    f.enc = ENC_BITS'(enc_pos);

    f.spd = SPEED_W'($urandom);
    f.cur = CURR_W'($urandom);
    if ($urandom_range(0, 9) == 0) f.spd = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
    if ($urandom_range(0, 9) == 0) f.cur = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
    f.tmp = TEMP_W'($urandom_range(0, 255));
    return f;
  endfunction

  // ------------------------------------------------------------------------
  // input side: drive at the falling edge, transfer seen at the rising edge
  // ------------------------------------------------------------------------
  task automatic send_frame(frame_t f);
    bit done;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
        in_if.valid = 1'b0;
      end else begin
        in_if.valid         = 1'b1;
        in_if.encoder_count = f.enc;
        in_if.speed_raw     = f.spd;
        in_if.current_raw   = f.cur;
        in_if.temp_raw      = f.tmp;
        @(posedge clk);
        if (in_if.ready) done = 1'b1;
      end
    end
  endtask

  // stop offering, then wait for the DUT to hand back everything it owes
  task automatic settle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic cfg_write(mfd_reg_t idx, logic [COEF_W-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_AW'(4 * int'(idx));
    pwdata  = APB_DW'(val);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == REG_SPEED_COEF) speed_coef = val;
    else curr_coef = val;
  endtask

  // ------------------------------------------------------------------------
  // result side: random stalls, plus one long hold-off on request
  // ------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = !(idle_en && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // in-order checker: each result transfer against the oldest expectation
  always @(posedge clk) begin
    angle_result_t got;
    angle_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.single  = out_if.angle_single;
      got.total   = out_if.angle_total;
      got.speed   = out_if.speed_smoothed;
      got.current = out_if.current_smoothed;
      got.temp    = out_if.temperature;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: single=%0d total=%0d speed=%0d current=%0d temp=%0d",
                   got.single, got.total, got.speed, got.current, got.temp);
      end else begin
        want = pending_results.pop_front();
        if (got.single !== want.single || got.total !== want.total ||
            got.speed !== want.speed || got.current !== want.current ||
            got.temp !== want.temp) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch exp: single=%0d total=%0d speed=%0d current=%0d temp=%0d",
                     want.single, want.total, want.speed, want.current, want.temp);
            $display("         got: single=%0d total=%0d speed=%0d current=%0d temp=%0d",
                     got.single, got.total, got.speed, got.current, got.temp);
          end
        end
      end
    end
  end

  // watchdog: any transfer on any port restarts the count
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("motor_feedback_decoder test failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    logic [COEF_W-1:0] speed_w [N_PHASES];
    logic [COEF_W-1:0] curr_w  [N_PHASES];
    angle_result_t     want;
    frame_t            f;

    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.encoder_count = '0;
    in_if.speed_raw     = '0;
    in_if.current_raw   = '0;
    in_if.temp_raw      = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    mismatches          = 0;

    last_count = '0;
    turns      = 0;
    speed_acc  = 0;
    curr_acc   = 0;
    speed_coef = '0;
    curr_coef  = '0;

    // weight settings per phase: none, heaviest, mixed, random, then two lopsided pairs
    speed_w = '{16'd0, 16'hffff, 16'h8000, COEF_W'($urandom), 16'd1, 16'hffff};
    curr_w  = '{16'd0, 16'hffff, 16'd1, COEF_W'($urandom), 16'hffff, 16'd0};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    for (int k = 0; k < N_DIRECTED; k++) begin
      send_frame(dir_table[k].frm);
      want = decode_frame(dir_table[k].frm);
      pending_results.push_back(dir_table[k].fixed ? dir_table[k].res : want);
    end

    // random phases; weights change only with the pipe drained
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      cfg_write(REG_SPEED_COEF, speed_w[ph]);
      cfg_write(REG_CURRENT_COEF, curr_w[ph]);
      idle_en = (ph != 3);  // phase 3 runs back to back on both sides
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // long hold-off while frames keep coming, so the input stalls
        if (ph == 2 && i == 40) hold_req = 1'b1;
        f = next_frame();
        send_frame(f);
        pending_results.push_back(decode_frame(f));
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("motor_feedback_decoder test passed");
    end else begin
      $display("motor_feedback_decoder test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mfd_pkg.sv
rtl/mfd_if.sv
rtl/motor_feedback_decoder.sv
rtl/mfd_checker.sv
test/tb_motor_feedback_decoder.sv
